>>> sv/cbgfm_pkg.sv
package cbgfm_pkg;

  // Design constants
  localparam int LANES            = 4;
  localparam int WORDS_PER_RECORD = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int WSEEN_W = $clog2(WORDS_PER_RECORD + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int LANE_IN_W = 8;
  localparam int SEQ_W     = 64;
  localparam int CTRL_W    = 8;
  localparam int DATA_W    = 64;
  localparam int HITS_W    = 4;
  localparam int WIDX_W    = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  // XGMII control codes
  localparam logic [7:0] START_CODE = 8'hFB;
  localparam logic [7:0] TERM_CODE  = 8'hFD;

  // Item function codes
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_WORD   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LANE   = CFG_IDX_W'(1);

  // Command passed from the classifier to the update stage.
  typedef struct packed {
    logic                  is_word;
    logic                  lane_ok;
    logic                  kept;
    logic [LANE_W-1:0]     lane;
    logic [SEQ_W-1:0]      seq;
    logic [HITS_W-1:0]     s_hits;
    logic [HITS_W-1:0]     t_hits;
    logic [WIDX_W-1:0]     widx;
  } cmd_t;

  // Number of control bytes of a word that carry the given code.
  function automatic logic [HITS_W-1:0] count_code(input logic [CTRL_W-1:0] ctrl,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic [7:0]        code);
    logic [HITS_W-1:0] n;
    n = '0;
    for (int i = 0; i < CTRL_W; i++) begin
      if (ctrl[i] && (data[8*i +: 8] == code)) begin
        n = n + HITS_W'(1);
      end
    end
    return n;
  endfunction

endpackage

>>> sv/cbgfm_if.sv
interface cbgfm_in_if import cbgfm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [LANE_IN_W-1:0] lane;
  logic [SEQ_W-1:0]     seq_no;
  logic [CTRL_W-1:0]    ctrl;
  logic [DATA_W-1:0]    data;

  modport source (output valid, func, lane, seq_no, ctrl, data, input ready);
  modport sink   (input valid, func, lane, seq_no, ctrl, data, output ready);
endinterface

interface cbgfm_out_if import cbgfm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    gap;
  logic signed [SEQ_W-1:0] seq_delta;
  logic [63:0]             gap_total;
  logic                    kept;
  logic [HITS_W-1:0]       start_hits;
  logic [HITS_W-1:0]       term_hits;
  logic [63:0]             lane_start_total;
  logic [63:0]             lane_term_total;
  logic [WIDX_W-1:0]       word_index;
  logic                    lane_error;

  modport source (output valid, gap, seq_delta, gap_total, kept, start_hits, term_hits,
                  lane_start_total, lane_term_total, word_index, lane_error,
                  input ready);
  modport sink   (input valid, gap, seq_delta, gap_total, kept, start_hits, term_hits,
                  lane_start_total, lane_term_total, word_index, lane_error,
                  output ready);
endinterface

interface cbgfm_cfg_if import cbgfm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

>>> sv/cbgfm_front.sv
module cbgfm_front import cbgfm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbgfm_in_if.sink     in_i,
  cbgfm_cfg_if.sink    cfg_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output cmd_t         q_cmd_o
);

  logic                 filter_en_q;
  logic [LANE_IN_W-1:0] filter_lane_q;
  logic [LANE_W-1:0]    rec_lane_q;
  logic                 rec_ok_q;
  logic                 rec_kept_q;
  logic [WIDX_W-1:0]    word_pos_q;
  logic [WSEEN_W-1:0]   words_seen_q;

  logic is_word;
  logic in_range;
  logic hdr_kept;
  logic room;

  assign in_i.ready  = !q_full_i;
  assign q_push_o    = in_i.valid && !q_full_i;
  assign cfg_i.ready = 1'b1;

  assign is_word  = (in_i.func == FUNC_WORD);
  assign in_range = (in_i.lane < LANE_IN_W'(LANES));
  assign hdr_kept = in_range && (!filter_en_q || (in_i.lane == filter_lane_q));
  assign room     = (words_seen_q < WSEEN_W'(WORDS_PER_RECORD));

  always_comb begin
    q_cmd_o.is_word = is_word;
    q_cmd_o.seq     = in_i.seq_no;
    if (is_word) begin
      q_cmd_o.lane_ok = rec_ok_q;
      q_cmd_o.kept    = rec_kept_q && rec_ok_q && room;
      q_cmd_o.lane    = rec_lane_q;
      q_cmd_o.s_hits  = count_code(in_i.ctrl, in_i.data, START_CODE);
      q_cmd_o.t_hits  = count_code(in_i.ctrl, in_i.data, TERM_CODE);
      q_cmd_o.widx    = word_pos_q;
    end else begin
      q_cmd_o.lane_ok = in_range;
      q_cmd_o.kept    = hdr_kept;
      q_cmd_o.lane    = in_i.lane[LANE_W-1:0];
      q_cmd_o.s_hits  = '0;
      q_cmd_o.t_hits  = '0;
      q_cmd_o.widx    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q   <= 1'b0;
      filter_lane_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        CFG_FILTER_ENABLE: filter_en_q   <= cfg_i.wdata[0];
        CFG_FILTER_LANE:   filter_lane_q <= cfg_i.wdata[LANE_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_lane_q   <= '0;
      rec_ok_q     <= 1'b1;
      rec_kept_q   <= 1'b0;
      word_pos_q   <= '0;
      words_seen_q <= '0;
    end else if (q_push_o) begin
      if (is_word) begin
        word_pos_q <= word_pos_q + WIDX_W'(1);
        if (room) begin
          words_seen_q <= words_seen_q + WSEEN_W'(1);
        end
      end else begin
        rec_lane_q   <= in_i.lane[LANE_W-1:0];
        rec_ok_q     <= in_range;
        rec_kept_q   <= hdr_kept;
        word_pos_q   <= '0;
        words_seen_q <= '0;
      end
    end
  end

endmodule

>>> sv/cbgfm_fifo.sv
module cbgfm_fifo import cbgfm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/cbgfm_back.sv
module cbgfm_back import cbgfm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  cbgfm_out_if.source   out_o
);

  logic [SEQ_W-1:0] last_seq_q [LANES];
  logic [63:0]      start_cnt_q [LANES];
  logic [63:0]      term_cnt_q [LANES];
  logic [63:0]      gap_cnt_q;
  logic [63:0]      gap_cnt_d;
  logic             out_valid_q;

  logic [SEQ_W-1:0] last;
  logic [SEQ_W-1:0] delta;
  logic [63:0]      st_old, tt_old, st_new, tt_new;
  logic             gap_now;
  logic             is_hdr_ok;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;

  always_comb begin
    last      = last_seq_q[cmd_i.lane];
    st_old    = start_cnt_q[cmd_i.lane];
    tt_old    = term_cnt_q[cmd_i.lane];
    is_hdr_ok = !cmd_i.is_word && cmd_i.lane_ok;
    delta     = cmd_i.seq - last;
    gap_now   = is_hdr_ok && (delta != SEQ_W'(1)) && (last != '0);
    st_new    = st_old + 64'(cmd_i.s_hits);
    tt_new    = tt_old + 64'(cmd_i.t_hits);
    gap_cnt_d = gap_cnt_q + 64'(gap_now);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      gap_cnt_q   <= '0;
      for (int i = 0; i < LANES; i++) begin
        last_seq_q[i]  <= '0;
        start_cnt_q[i] <= '0;
        term_cnt_q[i]  <= '0;
      end
    end else begin
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_pop_o) begin
        gap_cnt_q <= gap_cnt_d;
        if (is_hdr_ok && cmd_i.kept) begin
          last_seq_q[cmd_i.lane] <= cmd_i.seq;
        end
        if (cmd_i.is_word && cmd_i.kept) begin
          start_cnt_q[cmd_i.lane] <= st_new;
          term_cnt_q[cmd_i.lane]  <= tt_new;
        end
      end
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_o.gap        <= gap_now;
      out_o.seq_delta  <= is_hdr_ok ? delta : '0;
      out_o.gap_total  <= gap_cnt_d;
      out_o.kept       <= cmd_i.kept;
      out_o.start_hits <= cmd_i.s_hits;
      out_o.term_hits  <= cmd_i.t_hits;
      out_o.word_index <= cmd_i.widx;
      out_o.lane_error <= !cmd_i.lane_ok;
      if (cmd_i.lane_ok) begin
        out_o.lane_start_total <= cmd_i.kept ? st_new : st_old;
        out_o.lane_term_total  <= cmd_i.kept ? tt_new : tt_old;
      end else begin
        out_o.lane_start_total <= '0;
        out_o.lane_term_total  <= '0;
      end
    end
  end

endmodule

>>> sv/capture_block_gap_and_frame_monitor_unit.sv
// Path: a transaction accepted on in_i passes through the command queue and then the result
// register before it appears on out_o.
// Throughput: one transaction per cycle while out_o.ready keeps the per-lane counter update
// stage moving; a two-entry queue decouples that stage from the classifier.
// Reset (rst_ni, asynchronous, active low) clears all lane counters, the gap counter,
// the record tracking state, the queue and the filter registers.
module capture_block_gap_and_frame_monitor_unit import cbgfm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cbgfm_in_if.sink      in_i,
  cbgfm_cfg_if.sink     cfg_i,
  cbgfm_out_if.source   out_o
);

  // The front end accepts each transaction, works out which record and lane it belongs
  // to, applies the lane filter and counts start and terminate codes in word items.
  // Its decisions travel as one command per transaction through a short queue.
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  cbgfm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  // The queue lets the front end keep taking transactions while a finished result
  // waits in the output register for the downstream side.
  cbgfm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // The back end holds the per-lane sequence numbers and code totals, performs the
  // gap check and the counter updates, and registers the result transaction.
  cbgfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .out_o       (out_o)
  );

  // A result for an out-of-range lane never counts anything nor reports a gap.
  a_lane_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.lane_error |->
      !out_o.kept && !out_o.gap && (out_o.lane_start_total == '0) &&
      (out_o.lane_term_total == '0))
    else $error("lane error result carries counts");

  // A reported gap comes from a header whose delta is not one.
  a_gap_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.gap |->
      (out_o.seq_delta != 64'sd1) && (out_o.word_index == '0) &&
      (out_o.start_hits == '0) && (out_o.term_hits == '0))
    else $error("gap flagged on a non-header result");

  // With the pipeline empty, an accepted transaction reaches the output via the queue.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !q_valid && !out_o.valid |=> ##1 out_o.valid)
    else $error("result did not appear after two cycles");

endmodule
